/* src/utd_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 text decoder package
// Transfer types shared by the sequencer and the top level.
// ----------------------------------------------------------------------------
package utd_pkg;

	// One raw byte of a text buffer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic [5:0] modifiers;
	} in_item_t;

	// One decoded character or end marker
	typedef struct packed {
		logic [20:0] code_point;
		logic        char_valid;
		logic        buffer_end;
		logic [5:0]  modifiers_out;
	} out_item_t;

	// Result handed from the sequencer to the output stage
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} push_t;

	localparam int unsigned WinBytes = 4;

	typedef logic [WinBytes-1:0][7:0] window_t;

endpackage

/* src/utf8_text_decoder.sv */
// ----------------------------------------------------------------------------
// UTF-8 text decoder
// Turns the bytes of a text buffer into code points, dropping control codes.
// ----------------------------------------------------------------------------
// Usage:
//   text channel: one byte per transfer with last_byte on the buffer's final
//   byte and the key modifiers. text_stall is high while a byte is decoded.
//   cp channel: one decoded character per transfer; invalid or cut-short
//   sequences give their lead byte raw. The last result of a buffer has
//   buffer_end set; a buffer whose end yields no character gives one marker
//   with char_valid low.
//   Timing: a byte is decoded sequence by sequence, since the single decode
//   unit judges one sequence per cycle while no result waits on cp; the
//   next byte is taken once the sequencer is back in idle after its flush.
//   A kept character is held until the next kept one or the flush pushes it.
//   A stalled cp transfer holds its payload; the sequencer waits on it
//   whenever it has a further character to pass on.
//   Reset clears the pending byte count and empties the output register.
// ----------------------------------------------------------------------------
module utf8_text_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  utd_pkg::in_item_t   text_item,
	output logic                cp_valid,
	input  logic                cp_stall,
	output utd_pkg::out_item_t  cp_item
);
	import utd_pkg::*;

	push_t     push;
	logic      push_ok;
	logic      out_v_q;
	out_item_t out_q;

	utd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.push       (push),
		.push_ok    (push_ok)
	);

	assign push_ok = !out_v_q || !cp_stall;

	// Output register: load on push, release on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push.valid && push_ok) begin
			out_v_q <= 1'b1;
		end else if (!cp_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && push_ok) out_q <= push.item;
	end

	assign cp_valid = out_v_q;
	assign cp_item  = out_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_stall) |=> $stable(cp_item))
		else $error("stalled result overwritten");
	a_marker_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && !cp_item.char_valid) |-> cp_item.buffer_end)
		else $error("end marker without buffer end");
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && !cp_item.char_valid) |-> cp_item.code_point == 21'd0)
		else $error("end marker with nonzero code point");
`endif

endmodule

/* src/utd_decode.sv */
// ----------------------------------------------------------------------------
// UTF-8 sequence decode unit
// Judges the sequence at the head of the byte window: how many bytes it takes
// (zero when more bytes are needed) and the code point or raw lead byte.
// ----------------------------------------------------------------------------
module utd_decode (
	input  utd_pkg::window_t win,
	input  logic [2:0]       rem,
	input  logic             last,
	output logic [2:0]       used,
	output logic [20:0]      cp
);
	import utd_pkg::*;

	logic [7:0]  c0;
	logic [2:0]  need;
	logic        conts_ok;
	logic [10:0] v2;
	logic [15:0] v3;
	logic [20:0] v4;

	assign c0 = win[0];
	assign v2 = {c0[4:0], win[1][5:0]};
	assign v3 = {c0[3:0], win[1][5:0], win[2][5:0]};
	assign v4 = {c0[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};

	// Classify the lead byte; zero means it stands alone
	always_comb begin
		priority casez (c0)
			8'b110?????: need = 3'd2;
			8'b1110????: need = 3'd3;
			8'b11110???: need = 3'd4;
			default:     need = 3'd0;
		endcase
	end

	// Check only the continuation bytes that the sequence needs
	always_comb begin
		conts_ok = 1'b1;
		if (need >= 3'd2 && win[1][7:6] != 2'b10) conts_ok = 1'b0;
		if (need >= 3'd3 && win[2][7:6] != 2'b10) conts_ok = 1'b0;
		if (need == 3'd4 && win[3][7:6] != 2'b10) conts_ok = 1'b0;
	end

	// Decide length and value; fall back to the raw lead byte
	always_comb begin
		used = 3'd1;
		cp   = {13'd0, c0};
		if (!c0[7] || need == 3'd0) begin
			used = 3'd1;
		end else if (rem < need) begin
			used = last ? 3'd1 : 3'd0;
		end else if (conts_ok) begin
			unique case (need)
				3'd2: begin
					if (v2 >= 11'h080) begin
						used = 3'd2;
						cp   = {10'd0, v2};
					end
				end
				3'd3: begin
					if (v3 >= 16'h0800) begin
						used = 3'd3;
						cp   = {5'd0, v3};
					end
				end
				3'd4: begin
					if (v4 >= 21'h010000 && v4 <= 21'h10ffff) begin
						used = 3'd4;
						cp   = v4;
					end
				end
				default: begin
					used = 3'd1;
				end
			endcase
		end
	end

endmodule

/* src/utd_seq.sv */
// ----------------------------------------------------------------------------
// UTF-8 decode sequencer
// Loads the pending bytes and the new byte into a window, steps the decode
// unit over it one sequence per cycle unless a push waits, and holds back
// the latest kept character so the last one can carry the end-of-buffer flag.
// ----------------------------------------------------------------------------
module utd_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	input  utd_pkg::in_item_t text_item,
	output utd_pkg::push_t    push,
	input  logic              push_ok
);
	import utd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DEC   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       state_q;
	window_t          win_q;
	window_t          win_shift;
	logic [2:0]       rem_q;
	logic             last_q;
	logic [5:0]       mods_q;
	logic [2:0][7:0]  pend_q;
	logic [1:0]       pend_cnt_q;
	logic             hold_v_q;
	logic [20:0]      hold_cp_q;

	logic [2:0]  used;
	logic [20:0] cp;
	logic        kept;
	logic        need_push;
	logic        accept;

	utd_decode u_decode (
		.win  (win_q),
		.rem  (rem_q),
		.last (last_q),
		.used (used),
		.cp   (cp)
	);

	assign text_stall = (state_q != ST_IDLE);
	assign accept     = text_valid && !text_stall;
	assign kept       = (used != 3'd0) && (cp >= 21'd32) && (cp != 21'd127);
	assign need_push  = (state_q == ST_DEC) && (rem_q != 3'd0) && kept && hold_v_q;

	// Drop the consumed bytes off the head of the window
	always_comb begin
		logic [2:0] sel;
		for (int i = 0; i < WinBytes; i++) begin
			sel = 3'(i) + used;
			win_shift[i] = (sel < 3'(WinBytes)) ? win_q[sel[1:0]] : win_q[i];
		end
	end

	// Offer a held character, or the end marker at the buffer's end
	always_comb begin
		push.valid              = 1'b0;
		push.item.code_point    = hold_cp_q;
		push.item.char_valid    = 1'b1;
		push.item.buffer_end    = 1'b0;
		push.item.modifiers_out = mods_q;
		if (state_q == ST_DEC) begin
			push.valid = need_push;
		end else if (state_q == ST_FLUSH) begin
			push.valid           = hold_v_q || last_q;
			push.item.buffer_end = last_q;
			if (!hold_v_q) begin
				push.item.code_point = '0;
				push.item.char_valid = 1'b0;
			end
		end
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_cnt_q <= '0;
			hold_v_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (rem_q == 3'd0) begin
						pend_cnt_q <= '0;
						state_q    <= ST_FLUSH;
					end else if (used == 3'd0) begin
						pend_cnt_q <= rem_q[1:0];
						state_q    <= ST_FLUSH;
					end else if (!need_push || push_ok) begin
						if (kept) hold_v_q <= 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!push.valid || push_ok) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window, held character and pending bytes
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			for (int i = 0; i < WinBytes - 1; i++) begin
				win_q[i] <= (2'(i) == pend_cnt_q) ? text_item.data_byte : pend_q[i];
			end
			win_q[WinBytes-1] <= text_item.data_byte;
			rem_q  <= {1'b0, pend_cnt_q} + 3'd1;
			last_q <= text_item.last_byte;
			mods_q <= text_item.modifiers;
		end else if (state_q == ST_DEC && rem_q != 3'd0) begin
			if (used == 3'd0) begin
				for (int i = 0; i < WinBytes - 1; i++) begin
					pend_q[i] <= win_q[i];
				end
			end else if (!need_push || push_ok) begin
				win_q <= win_shift;
				rem_q <= rem_q - used;
				if (kept) hold_cp_q <= cp;
			end
		end
	end

`ifndef SYNTHESIS
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DEC |-> rem_q <= 3'd4)
		else $error("window count above four");
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_v_q)
		else $error("held character left over in idle");
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && last_q) |-> pend_cnt_q == 2'd0)
		else $error("pending bytes kept past buffer end");
	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (state_q == ST_DEC || state_q == ST_FLUSH))
		else $error("result offered while idle");
	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(need_push && !push_ok) |=> $stable(rem_q) && $stable(hold_cp_q))
		else $error("window moved while result waited");
`endif

endmodule
